// ===== src/mssp_pkg.sv =====
package mssp_pkg;

	// field widths fixed by the interface
	localparam int VERTEX_W = 4;
	localparam int COST_W   = 14;
	localparam int CFG_W    = 5;

	// cost that marks a missing edge or an unreachable vertex
	localparam logic [COST_W-1:0] NO_EDGE = COST_W'(9999);

	// reset value of the vertex count register
	localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(16);

	typedef logic [COST_W-1:0] cost_t;

endpackage

// ===== src/mssp_ram.sv =====
module mssp_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/multistage_shortest_path.sv =====
// Shortest path through a layered graph whose edges run from lower to higher
// vertex index. Edges come in on the input channel (valid/ready), one per
// cycle while idle, and are written into an edge cost memory; a later edge for
// the same pair replaces the earlier one, backward or self edges are dropped.
// The transaction flagged last_edge starts a backward relaxation pass from the
// destination (vertex_count - 1) to vertex 0. Each row i reads its edge costs
// and the stored distances one per cycle from the two memories, then writes
// its minimum to the distance memory; after row 0 the result is handed to the
// output register.
// min_cost (9999 = unreachable) is held on the output channel until taken;
// the block carries on while it waits, and only a second result stalls
// behind an untaken one.
// After reset and after each result, the edge memory is swept back to the
// no-edge value, one entry per cycle; in_ready stays low during the sweep.
// Configuration writes to vertex_count (cfg_we / cfg_wdata, no wait) are
// taken at any time and belong in idle time.
// vertex_count resets to 16; zero acts as one, above MAX_VERTICES saturates.
module multistage_shortest_path
	import mssp_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [VERTEX_W-1:0] from_vertex,
	input  logic [VERTEX_W-1:0] to_vertex,
	input  logic [COST_W-1:0]   weight,
	input  logic                last_edge,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COST_W-1:0]   min_cost
);

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int TW    = $clog2(DEPTH);
	localparam logic [TW-1:0] ROW_STRIDE = TW'(MAX_VERTICES);
	localparam logic [TW-1:0] LAST_ADDR  = TW'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RELAX,
		ST_ROW_END,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [CFG_W-1:0] vcount_q;
	logic [TW-1:0]   clr_q;
	logic [CW-1:0]   n_q;
	logic [VW-1:0]   i_q;
	logic [VW-1:0]   j_q;
	cost_t           acc_q;
	cost_t           res_q;
	logic            vld_s1;
	logic            dest_s1;
	logic            out_valid_q;
	cost_t           min_cost_q;

	logic            in_fire;
	logic            edge_ok;
	cost_t           weight_sat;
	logic [CW-1:0]   n_clamp;
	logic            last_j;
	logic            out_load;

	logic            tbl_we;
	logic [TW-1:0]   tbl_waddr;
	cost_t           tbl_wdata;
	logic [TW-1:0]   tbl_raddr;
	cost_t           tbl_rdata;
	logic            dist_we;
	cost_t           dist_rdata;

	cost_t           dist_val;
	logic [COST_W:0] sum;
	cost_t           fold;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	// vertex count clamped to 1..MAX_VERTICES
	always_comb begin
		if (vcount_q == '0) begin
			n_clamp = CW'(1);
		end else if (int'(vcount_q) > MAX_VERTICES) begin
			n_clamp = CW'(MAX_VERTICES);
		end else begin
			n_clamp = CW'(vcount_q);
		end
	end

	// incoming edge checks
	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign weight_sat = (weight > NO_EDGE) ? NO_EDGE : weight;
	assign edge_ok    = (to_vertex > from_vertex) && (int'(from_vertex) < MAX_VERTICES)
		&& (int'(to_vertex) < MAX_VERTICES);

	// edge memory write port: clearing sweep or incoming edge
	always_comb begin
		if (state_q == ST_CLEAR) begin
			tbl_we    = 1'b1;
			tbl_waddr = clr_q;
			tbl_wdata = NO_EDGE;
		end else begin
			tbl_we    = in_fire && edge_ok;
			tbl_waddr = TW'(from_vertex) * ROW_STRIDE + TW'(to_vertex);
			tbl_wdata = weight_sat;
		end
	end

	assign tbl_raddr = TW'(i_q) * ROW_STRIDE + TW'(j_q);
	assign last_j    = (CW'(j_q) == n_q - CW'(1));

	// fold the candidate read in the previous cycle into the row minimum
	assign dist_val = dest_s1 ? '0 : dist_rdata;
	assign sum      = {1'b0, tbl_rdata} + {1'b0, dist_val};
	always_comb begin
		if (vld_s1 && (tbl_rdata != NO_EDGE) && (sum < {1'b0, acc_q})) begin
			fold = sum[COST_W-1:0];
		end else begin
			fold = acc_q;
		end
	end

	assign dist_we = (state_q == ST_ROW_END);

	// result register loads when it is empty or being taken
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	mssp_ram #(
		.WIDTH(COST_W),
		.DEPTH(DEPTH)
	) u_edge_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	mssp_ram #(
		.WIDTH(COST_W),
		.DEPTH(MAX_VERTICES)
	) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (i_q),
		.wdata (fold),
		.raddr (j_q),
		.rdata (dist_rdata)
	);

	// sequencer: sweep, edge intake, relaxation rows, result handoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			acc_q       <= NO_EDGE;
			res_q       <= '0;
			vld_s1      <= 1'b0;
			dest_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			min_cost_q  <= '0;
		end else begin
			vld_s1  <= (state_q == ST_RELAX);
			dest_s1 <= last_j;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == LAST_ADDR) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + TW'(1);
					end
				end
				ST_IDLE: begin
					if (in_fire && last_edge) begin
						n_q   <= n_clamp;
						acc_q <= NO_EDGE;
						if (n_clamp == CW'(1)) begin
							res_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							i_q     <= VW'(n_clamp - CW'(2));
							j_q     <= VW'(n_clamp - CW'(1));
							state_q <= ST_RELAX;
						end
					end
				end
				ST_RELAX: begin
					acc_q <= fold;
					if (last_j) begin
						state_q <= ST_ROW_END;
					end else begin
						j_q <= j_q + VW'(1);
					end
				end
				ST_ROW_END: begin
					acc_q <= NO_EDGE;
					if (i_q == '0) begin
						res_q   <= fold;
						state_q <= ST_DONE;
					end else begin
						j_q     <= i_q;
						i_q     <= i_q - VW'(1);
						state_q <= ST_RELAX;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						min_cost_q <= res_q;
						state_q    <= ST_CLEAR;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign min_cost  = min_cost_q;

endmodule

// ===== tb/sv/tb_multistage_shortest_path.sv =====
`timescale 1ns / 100ps

module tb_multistage_shortest_path;
	import mssp_pkg::*;

	localparam int MAX_V = 16;
	localparam int N_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 60;
	// covers the edge memory sweep after the last result is taken
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic [VERTEX_W-1:0] src;
		logic [VERTEX_W-1:0] dst;
		cost_t               cost;
	} arc_t;

	// predicted edge table, vertex count and pending path costs
	class cost_board;
		cost_t       arc_cost[MAX_V][MAX_V];
		int unsigned vcount;
		cost_t       expected_costs[$];
		int          errors;

		function new();
			clear_arcs();
			vcount = VCOUNT_RESET;
			errors = 0;
		endfunction

		function void clear_arcs();
			for (int i = 0; i < MAX_V; i++)
				for (int j = 0; j < MAX_V; j++)
					arc_cost[i][j] = NO_EDGE;
		endfunction

		function void set_vertex_count(int unsigned value);
			vcount = value;
		endfunction

		function int pending();
			return expected_costs.size();
		endfunction

		// backward relaxation from the destination down to vertex 0
		function cost_t shortest_cost();
			int n;
			int best;
			int sum;
			int dist_to[MAX_V];
			n = vcount;
			if (n < 1)
				n = 1;
			if (n > MAX_V)
				n = MAX_V;
			dist_to[n-1] = 0;
			for (int i = n - 2; i >= 0; i--) begin
				best = NO_EDGE;
				for (int j = i + 1; j < n; j++)
					if (arc_cost[i][j] != NO_EDGE) begin
						sum = arc_cost[i][j] + dist_to[j];
						if (sum < best)
							best = sum;
					end
				dist_to[i] = best;
			end
			return cost_t'(dist_to[0]);
		endfunction

		// accepted input transaction
		function void note_edge(logic [VERTEX_W-1:0] src, logic [VERTEX_W-1:0] dst,
			cost_t w, logic last);
			cost_t c;
			c = (w > NO_EDGE) ? NO_EDGE : w;
			if (dst > src)
				arc_cost[src][dst] = c;
			if (last) begin
				expected_costs.push_back(shortest_cost());
				clear_arcs();
			end
		endfunction

		// accepted output transaction
		function void check_cost(cost_t actual);
			cost_t want;
			if (expected_costs.size() == 0) begin
				$error("min_cost: no transaction expected, actual %0d", actual);
				errors++;
			end else begin
				want = expected_costs.pop_front();
				if (actual !== want) begin
					$error("min_cost: expected %0d, actual %0d", want, actual);
					errors++;
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic [VERTEX_W-1:0] from_vertex;
	logic [VERTEX_W-1:0] to_vertex;
	logic [COST_W-1:0]   weight;
	logic                last_edge;
	logic                out_valid;
	logic                out_ready;
	logic [COST_W-1:0]   min_cost;

	cost_board board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;

	multistage_shortest_path #(
		.MAX_VERTICES(MAX_V)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.from_vertex(from_vertex),
		.to_vertex(to_vertex),
		.weight(weight),
		.last_edge(last_edge),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.min_cost(min_cost)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// one edge transaction with random idle cycles ahead of it
	task automatic send_edge(input logic [VERTEX_W-1:0] src, input logic [VERTEX_W-1:0] dst,
		input cost_t w, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		from_vertex <= src;
		to_vertex   <= dst;
		weight      <= w;
		last_edge   <= last;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_edge(src, dst, w, last);
		items_sent++;
	endtask

	// idle until every path cost is back and the sweep is over
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.set_vertex_count(value);
	endtask

	function automatic cost_t pick_weight();
		int sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return cost_t'($urandom_range(0, 40));
		else if (sel < 75)
			return cost_t'($urandom_range(0, 9999));
		else if (sel < 85)
			return NO_EDGE;
		else if (sel < 90)
			return cost_t'(NO_EDGE - 1);
		else
			return cost_t'($urandom_range(0, 16383));
	endfunction

	// one graph: mostly a forward chain to the destination plus extra arcs,
	// some noise, shuffled, with the final arc flagged last
	task automatic run_graph(input int unsigned vc);
		arc_t arcs[$];
		arc_t a;
		arc_t tmp;
		int n;
		int v;
		int hop;
		int extras;
		int k;
		n = (vc < 1) ? 1 : ((vc > MAX_V) ? MAX_V : vc);
		if (n >= 2 && $urandom_range(99) < 70) begin
			v = 0;
			while (v < n - 1) begin
				hop = $urandom_range(1, (n - 1 - v < 3) ? n - 1 - v : 3);
				a.src = VERTEX_W'(v);
				a.dst = VERTEX_W'(v + hop);
				a.cost = pick_weight();
				arcs.push_back(a);
				v += hop;
			end
		end
		extras = $urandom_range(0, 6);
		for (int e = 0; e < extras; e++) begin
			if (n >= 2 && $urandom_range(99) < 80) begin
				a.src = VERTEX_W'($urandom_range(0, n - 2));
				a.dst = VERTEX_W'($urandom_range(a.src + 1, n - 1));
				a.cost = pick_weight();
			end else begin
				a.src = VERTEX_W'($urandom_range(0, 15));
				a.dst = VERTEX_W'($urandom_range(0, 15));
				a.cost = cost_t'($urandom_range(0, 16383));
			end
			arcs.push_back(a);
		end
		if (arcs.size() == 0) begin
			a.src = VERTEX_W'($urandom_range(0, 15));
			a.dst = VERTEX_W'($urandom_range(0, 15));
			a.cost = pick_weight();
			arcs.push_back(a);
		end
		for (int i = arcs.size() - 1; i > 0; i--) begin
			k = $urandom_range(0, i);
			tmp = arcs[i];
			arcs[i] = arcs[k];
			arcs[k] = tmp;
		end
		for (int i = 0; i < arcs.size(); i++)
			send_edge(arcs[i].src, arcs[i].dst, arcs[i].cost, i == arcs.size() - 1);
	endtask

	// output side: check each result transaction, stall at random
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_cost(min_cost);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// stimulus
	initial begin
		int unsigned phase_counts[N_PHASES];
		int unsigned vc;
		int start;
		phase_counts = '{16, 1, 0, 31, 2, 17, 7, 11, 4, 16};
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= VCOUNT_RESET;
		in_valid    <= 1'b0;
		from_vertex <= '0;
		to_vertex   <= '0;
		weight      <= '0;
		last_edge   <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no-edge, backward, self and oversized weights
		send_edge(4'd0, 4'd15, NO_EDGE, 1'b0);
		send_edge(4'd15, 4'd3, 14'd5, 1'b0);
		send_edge(4'd7, 4'd7, 14'd1, 1'b0);
		send_edge(4'd0, 4'd15, 14'h3FFF, 1'b1);
		// overwrite of the same pair
		send_edge(4'd0, 4'd15, 14'd100, 1'b0);
		send_edge(4'd0, 4'd15, 14'd40, 1'b0);
		send_edge(4'd0, 4'd8, 14'd30, 1'b0);
		send_edge(4'd8, 4'd15, 14'd20, 1'b1);
		// long path saturates to unreachable
		send_edge(4'd0, 4'd5, cost_t'(NO_EDGE - 1), 1'b0);
		send_edge(4'd5, 4'd15, 14'd1, 1'b1);
		send_edge(4'd0, 4'd15, cost_t'(NO_EDGE - 1), 1'b1);
		// table cleared after the previous result
		send_edge(4'd3, 4'd4, 14'd7, 1'b1);
		// multi-hop chain with zero weight
		send_edge(4'd0, 4'd3, 14'd0, 1'b0);
		send_edge(4'd3, 4'd6, 14'd9, 1'b0);
		send_edge(4'd6, 4'd9, 14'd0, 1'b0);
		send_edge(4'd9, 4'd12, 14'd2, 1'b0);
		send_edge(4'd12, 4'd15, 14'd0, 1'b1);
		drain();

		// random phases across vertex counts and idling modes
		for (int p = 0; p < N_PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			vc = (p >= 6 && p <= 8) ? $urandom_range(3, 15) : phase_counts[p];
			write_vertex_count(CFG_W'(vc));
			start = items_sent;
			while (items_sent - start < ITEMS_PER_PHASE)
				run_graph(vc);
			drain();
		end

		if (board.errors == 0)
			$display("tb_multistage_shortest_path passed");
		else
			$display("tb_multistage_shortest_path failed");
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("tb_multistage_shortest_path failed");
		$finish;
	end

endmodule
